// File: rtl/scch_pkg.sv
// Package: shared types, constants and lookup functions for the coincidence hit builder.
`timescale 1ns / 1ps
package scch_pkg;

	localparam int HODO_PER_LAYER_DEF = 3;
	localparam int STRIP_PER_SIDE_DEF = 3;
	localparam int SLOTS  = 3;
	localparam int NLISTS = 10;
	localparam int DEPTH  = NLISTS * SLOTS;
	localparam int AW     = $clog2(DEPTH);

	// station kinds walked during pairing, in this order
	localparam logic [2:0] KIND_HODO1  = 3'd0;
	localparam logic [2:0] KIND_HODO2  = 3'd1;
	localparam logic [2:0] KIND_STRIP0 = 3'd2;
	localparam logic [2:0] KIND_STRIP1 = 3'd3;
	localparam logic [2:0] KIND_STRIP2 = 3'd4;
	localparam logic [2:0] KIND_END    = 3'd5;

	localparam logic [36:0] NO_HIT_SUM = 37'd31968;
	localparam logic signed [37:0] GATE_LO = -38'sd3520;
	localparam logic signed [37:0] GATE_HI = -38'sd2720;

	typedef struct packed {
		logic [9:0]  id;
		logic [31:0] addr;
		logic [17:0] mean;
		logic [15:0] err;
		logic [35:0] tm;
	} entry_t;

	typedef struct packed {
		logic [2:0]  station;
		logic [9:0]  front_id;
		logic [9:0]  back_id;
		logic [31:0] addr;
		logic [20:0] pos_x;
		logic [20:0] pos_y;
		logic [21:0] pos_z;
		logic [17:0] err_x;
		logic [17:0] err_y;
		logic [35:0] tm;
	} hit_t;

	// controller -> datapath
	typedef struct packed {
		logic       accept;
		logic [2:0] kind;
		logic [1:0] fi;
		logic [1:0] bi;
		logic       commit;
		logic       flush;
		logic       clear;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] nf;
		logic [1:0] nb;
		logic       close_ok;
		logic       gate_ok;
		logic       out_free;
		logic       pend_valid;
	} sts_t;

	function automatic logic [3:0] front_list(input logic [2:0] kind);
		case (kind)
			KIND_HODO1:  front_list = 4'd1;
			KIND_HODO2:  front_list = 4'd3;
			KIND_STRIP0: front_list = 4'd4;
			KIND_STRIP1: front_list = 4'd6;
			default:     front_list = 4'd8;
		endcase
	endfunction

	function automatic logic [3:0] back_list(input logic [2:0] kind);
		case (kind)
			KIND_HODO1:  back_list = 4'd0;
			KIND_HODO2:  back_list = 4'd2;
			KIND_STRIP0: back_list = 4'd5;
			KIND_STRIP1: back_list = 4'd7;
			default:     back_list = 4'd9;
		endcase
	endfunction

	function automatic logic [AW-1:0] slot_addr(input logic [3:0] list, input logic [1:0] s);
		slot_addr = AW'(int'(list) * SLOTS + int'(s));
	endfunction

	function automatic logic [2:0] station_code(input logic [2:0] kind);
		case (kind)
			KIND_HODO1:  station_code = 3'd0;
			KIND_HODO2:  station_code = 3'd4;
			KIND_STRIP0: station_code = 3'd1;
			KIND_STRIP1: station_code = 3'd3;
			default:     station_code = 3'd2;
		endcase
	endfunction

	function automatic logic [21:0] z_pos(input logic [2:0] kind);
		case (kind)
			KIND_HODO1:  z_pos = 22'd59000;
			KIND_HODO2:  z_pos = 22'd3019000;
			KIND_STRIP0: z_pos = 22'd254000;
			KIND_STRIP1: z_pos = 22'd1234000;
			default:     z_pos = 22'd700000;
		endcase
	endfunction

	// window center, 1/16 ns
	function automatic logic signed [37:0] win_shift(input logic [2:0] kind, input logic trig);
		case (kind)
			KIND_HODO1, KIND_HODO2: win_shift = 38'sd0;
			KIND_STRIP0:            win_shift = -38'sd96;
			KIND_STRIP1:            win_shift = -38'sd64;
			default:                win_shift = trig ? 38'sd608 : 38'sd160;
		endcase
	endfunction

	// window half width, 1/16 ns, strict
	function automatic logic [37:0] win_limit(input logic [2:0] kind, input logic trig);
		case (kind)
			KIND_HODO1, KIND_HODO2: win_limit = 38'd160;
			KIND_STRIP0:            win_limit = 38'd320;
			KIND_STRIP1:            win_limit = 38'd352;
			default:                win_limit = trig ? 38'd64 : 38'd288;
		endcase
	endfunction

	function automatic logic [20:0] sat_pos(input logic signed [45:0] v);
		if (v > 46'sd1048575)
			sat_pos = 21'h0FFFFF;
		else if (v < -46'sd1048576)
			sat_pos = 21'h100000;
		else
			sat_pos = v[20:0];
	endfunction

	function automatic logic [17:0] sat_err(input logic [26:0] p);
		logic [27:0] r;
		r = (28'(p) + 28'd128) >> 8;
		sat_err = (r > 28'd262143) ? 18'h3FFFF : r[17:0];
	endfunction

endpackage

// File: rtl/scch_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module scch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/scch_ctrl.sv
// Controller: load/close/pair/flush sequencing for the hit builder.
`timescale 1ns / 1ps
module scch_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          last_cluster,
	input  scch_pkg::sts_t sts,
	output scch_pkg::cmd_t cmd,
	output logic          in_stall
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_CLOSE, ST_KIND, ST_RD, ST_MUL, ST_OUT, ST_FLUSH
	} state_t;

	state_t     state_q;
	logic [2:0] kind_q;
	logic [1:0] fi_q, bi_q;
	logic       stall_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= scch_pkg::KIND_HODO1;
			fi_q    <= '0;
			bi_q    <= '0;
			stall_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && last_cluster) begin
						state_q <= ST_CLOSE;
						stall_q <= 1'b1;
					end
				end
				ST_CLOSE: begin
					kind_q  <= scch_pkg::KIND_HODO1;
					state_q <= sts.close_ok ? ST_KIND : ST_FLUSH;
				end
				ST_KIND: begin
					fi_q <= '0;
					bi_q <= '0;
					if (kind_q == scch_pkg::KIND_END ||
					    (kind_q == scch_pkg::KIND_STRIP0 && !sts.gate_ok))
						state_q <= ST_FLUSH;
					else if (sts.nf == 2'd0 || sts.nb == 2'd0)
						kind_q <= kind_q + 3'd1;
					else
						state_q <= ST_RD;
				end
				ST_RD:  state_q <= ST_MUL;
				ST_MUL: state_q <= ST_OUT;
				ST_OUT: begin
					if (sts.out_free) begin
						if (bi_q + 2'd1 < sts.nb) begin
							bi_q    <= bi_q + 2'd1;
							state_q <= ST_RD;
						end else if (fi_q + 2'd1 < sts.nf) begin
							fi_q    <= fi_q + 2'd1;
							bi_q    <= '0;
							state_q <= ST_RD;
						end else begin
							kind_q  <= kind_q + 3'd1;
							state_q <= ST_KIND;
						end
					end
				end
				ST_FLUSH: begin
					if (!sts.pend_valid || sts.out_free) begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

	assign in_stall = stall_q;

	always_comb begin
		cmd        = '0;
		cmd.kind   = kind_q;
		cmd.fi     = fi_q;
		cmd.bi     = bi_q;
		cmd.accept = (state_q == ST_IDLE) && in_valid;
		cmd.commit = (state_q == ST_OUT) && sts.out_free;
		cmd.flush  = (state_q == ST_FLUSH) && sts.pend_valid && sts.out_free;
		cmd.clear  = (state_q == ST_FLUSH) && (!sts.pend_valid || sts.out_free);
	end
endmodule

// File: rtl/scch_dp.sv
// Datapath: cluster store, list fills, window check, position math, hit registers.
`timescale 1ns / 1ps
module scch_dp #(
	parameter int HODO_PER_LAYER = scch_pkg::HODO_PER_LAYER_DEF,
	parameter int STRIP_PER_SIDE = scch_pkg::STRIP_PER_SIDE_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  scch_pkg::cmd_t cmd,
	output scch_pkg::sts_t sts,
	input  logic           cfg_wr_en,
	input  logic           cfg_wr_data,
	input  logic           is_strip,
	input  logic [4:0]     layer_code,
	input  logic [9:0]     cluster_id,
	input  logic [31:0]    cluster_address,
	input  logic [17:0]    mean_channel,
	input  logic [15:0]    mean_error,
	input  logic [35:0]    cluster_time,
	input  logic           out_stall,
	output logic           out_valid,
	output scch_pkg::hit_t out_hit,
	output logic           out_last
);
	localparam int AW = scch_pkg::AW;

	logic              trig_q;
	logic [2:0]        fill_q [scch_pkg::NLISTS];
	logic              any_hodo_q, any_strip_q;
	logic [36:0]       pair_sum_q [2];

	// ---- load side ----
	logic       lst_ok;
	logic [3:0] lst;
	logic [2:0] cap_in, f_in;
	always_comb begin
		lst_ok = 1'b0;
		lst    = '0;
		if (is_strip) begin
			lst_ok = (layer_code <= 5'd5);
			if (lst_ok)
				lst = 4'(layer_code[2:0]) + 4'd4;
		end else begin
			case (layer_code)
				5'd0:    begin lst_ok = 1'b1; lst = 4'd0; end
				5'd16:   begin lst_ok = 1'b1; lst = 4'd1; end
				5'd1:    begin lst_ok = 1'b1; lst = 4'd2; end
				5'd17:   begin lst_ok = 1'b1; lst = 4'd3; end
				default: begin lst_ok = 1'b0; lst = 4'd0; end
			endcase
		end
		cap_in = is_strip ? 3'(STRIP_PER_SIDE) : 3'(HODO_PER_LAYER);
		f_in   = fill_q[lst];
	end

	logic wr_en;
	assign wr_en = cmd.accept && lst_ok && (f_in < cap_in);

	scch_pkg::entry_t wentry, fent, bent;
	assign wentry = '{id: cluster_id, addr: cluster_address, mean: mean_channel,
	                  err: mean_error, tm: cluster_time};

	logic [3:0]    fl, bl;
	logic [AW-1:0] waddr;
	assign fl    = scch_pkg::front_list(cmd.kind);
	assign bl    = scch_pkg::back_list(cmd.kind);
	assign waddr = scch_pkg::slot_addr(lst, f_in[1:0]);

	scch_ram #(.WIDTH($bits(scch_pkg::entry_t)), .DEPTH(scch_pkg::DEPTH)) u_ram_f (
		.clk(clk), .we(wr_en), .waddr(waddr), .wdata(wentry),
		.raddr(scch_pkg::slot_addr(fl, cmd.fi)), .rdata(fent)
	);
	scch_ram #(.WIDTH($bits(scch_pkg::entry_t)), .DEPTH(scch_pkg::DEPTH)) u_ram_b (
		.clk(clk), .we(wr_en), .waddr(waddr), .wdata(wentry),
		.raddr(scch_pkg::slot_addr(bl, cmd.bi)), .rdata(bent)
	);

	// ---- stage 1: window and products ----
	logic is_hodo, is_s2;
	assign is_hodo = (cmd.kind == scch_pkg::KIND_HODO1) || (cmd.kind == scch_pkg::KIND_HODO2);
	assign is_s2   = (cmd.kind == scch_pkg::KIND_STRIP2);

	logic signed [37:0] dt, dabs;
	logic signed [19:0] mf, mb, off, xa, ya;
	logic signed [11:0] xm;
	logic signed [25:0] ym;
	logic        [10:0] em;
	always_comb begin
		dt   = signed'({2'b00, bent.tm}) - signed'({2'b00, fent.tm})
		       - scch_pkg::win_shift(cmd.kind, trig_q);
		dabs = dt[37] ? -dt : dt;
		mf   = signed'({2'b00, fent.mean});
		mb   = signed'({2'b00, bent.mean});
		if (is_hodo) begin
			off = -20'sd8320;  xm = 12'sd1010; em = 11'd1000;
		end else if (is_s2) begin
			off = 20'sd114688; xm = 12'sd58;   em = 11'd58;
		end else begin
			off = -20'sd32512; xm = 12'sd50;   em = 11'd50;
		end
		xa = mf + off;
		ya = is_s2 ? (mf - mb - 20'sd17152) : (mb + off);
		ym = is_s2 ? 26'sd28872130 : 26'(xm);
	end

	logic               win_s1;
	logic signed [31:0] px_s1;
	logic signed [45:0] py_s1;
	logic [26:0]        ex_s1, ey_s1;
	logic [36:0]        sum_s1;
	logic [9:0]         fid_s1, bid_s1;
	logic [31:0]        addr_s1;

	always_ff @(posedge clk) begin
		win_s1  <= (unsigned'(dabs) < scch_pkg::win_limit(cmd.kind, trig_q));
		px_s1   <= xa * 32'(xm);
		py_s1   <= ya * ym;
		ex_s1   <= fent.err * em;
		ey_s1   <= bent.err * em;
		sum_s1  <= 37'(fent.tm) + 37'(bent.tm);
		fid_s1  <= fent.id;
		bid_s1  <= bent.id;
		addr_s1 <= fent.addr;
	end

	// ---- stage 2: rounding, saturation ----
	logic signed [31:0] xr, xf;
	logic signed [45:0] yr, yf;
	scch_pkg::hit_t     hit_new;
	always_comb begin
		xr = (px_s1 + 32'sd128) >>> 8;
		xf = is_s2 ? (xr - 32'sd30000) : xr;
		yr = is_s2 ? ((py_s1 + 46'sd8388608) >>> 24) : ((py_s1 + 46'sd128) >>> 8);
		yf = is_s2 ? (yr + 46'sd30000) : yr;
		hit_new.station  = scch_pkg::station_code(cmd.kind);
		hit_new.front_id = fid_s1;
		hit_new.back_id  = bid_s1;
		hit_new.addr     = addr_s1;
		hit_new.pos_x    = scch_pkg::sat_pos(46'(xf));
		hit_new.pos_y    = scch_pkg::sat_pos(yf);
		hit_new.pos_z    = scch_pkg::z_pos(cmd.kind);
		hit_new.err_x    = scch_pkg::sat_err(ex_s1);
		hit_new.err_y    = scch_pkg::sat_err(ey_s1);
		hit_new.tm       = sum_s1[36:1];
	end

	// ---- pending hit and output register ----
	scch_pkg::hit_t pend_q;
	logic           pend_valid_q;
	logic           out_valid_q, out_last_q;
	scch_pkg::hit_t out_q;
	logic           push;
	assign push = (cmd.commit && win_s1 && pend_valid_q) || cmd.flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			out_valid_q <= push || (out_valid_q && out_stall);
			if (cmd.commit && win_s1)
				pend_valid_q <= 1'b1;
			else if (cmd.flush)
				pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q      <= pend_q;
			out_last_q <= cmd.flush;
		end
		if (cmd.commit && win_s1)
			pend_q <= hit_new;
	end

	// ---- event state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q        <= 1'b0;
			any_hodo_q    <= 1'b0;
			any_strip_q   <= 1'b0;
			pair_sum_q[0] <= scch_pkg::NO_HIT_SUM;
			pair_sum_q[1] <= scch_pkg::NO_HIT_SUM;
			for (int i = 0; i < scch_pkg::NLISTS; i++)
				fill_q[i] <= '0;
		end else begin
			if (cfg_wr_en)
				trig_q <= cfg_wr_data;
			if (cmd.accept) begin
				if (is_strip)
					any_strip_q <= 1'b1;
				else
					any_hodo_q <= 1'b1;
				if (lst_ok && (f_in < cap_in || (lst < 4'd4 && f_in <= cap_in)))
					fill_q[lst] <= f_in + 3'd1;
			end
			if (cmd.commit && win_s1 && is_hodo)
				pair_sum_q[cmd.kind[0]] <= sum_s1;
			if (cmd.clear) begin
				any_hodo_q    <= 1'b0;
				any_strip_q   <= 1'b0;
				pair_sum_q[0] <= scch_pkg::NO_HIT_SUM;
				pair_sum_q[1] <= scch_pkg::NO_HIT_SUM;
				for (int i = 0; i < scch_pkg::NLISTS; i++)
					fill_q[i] <= '0;
			end
		end
	end

	// ---- status ----
	logic [2:0]         cap_k, nf_raw, nb_raw;
	logic signed [37:0] gdt;
	always_comb begin
		cap_k  = is_hodo ? 3'(HODO_PER_LAYER) : 3'(STRIP_PER_SIDE);
		nf_raw = (fill_q[fl] > cap_k) ? cap_k : fill_q[fl];
		nb_raw = (fill_q[bl] > cap_k) ? cap_k : fill_q[bl];
		gdt    = signed'({1'b0, pair_sum_q[1]}) - signed'({1'b0, pair_sum_q[0]});
		sts.nf         = nf_raw[1:0];
		sts.nb         = nb_raw[1:0];
		sts.close_ok   = any_hodo_q && any_strip_q &&
		                 fill_q[0] <= 3'(HODO_PER_LAYER) && fill_q[1] <= 3'(HODO_PER_LAYER) &&
		                 fill_q[2] <= 3'(HODO_PER_LAYER) && fill_q[3] <= 3'(HODO_PER_LAYER);
		sts.gate_ok    = (gdt >= scch_pkg::GATE_LO) && (gdt <= scch_pkg::GATE_HI);
		sts.out_free   = !out_valid_q || !out_stall;
		sts.pend_valid = pend_valid_q;
	end

	assign out_valid = out_valid_q;
	assign out_hit   = out_q;
	assign out_last  = out_last_q;
endmodule

// File: rtl/strip_cluster_coincidence_hits.sv
// Top level: strip/hodoscope coincidence hit builder.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------------------
//  in       | request   | in_valid / in_stall | is_strip .. cluster_time, last_cluster
//  out      | result    | out_valid/out_stall | station_code .. hit_time, last_hit
//  cfg      | write     | cfg_wr_en           | cfg_wr_data (triggered_mode)
//
// The store accepts a cluster every cycle while in_stall is low.
// The request with last_cluster closes the event: a close check, a visit to each station kind,
// a RAM read, multiply stage and round-and-commit step for each front/back pair, and a flush;
// output stalls hold the commit and flush steps.
// in_stall is high from the cycle after the closing request until the event's last hit has
// moved into the output register.
// arst_n clears control, fills, hodoscope pair times and the triggered_mode register.
// The cluster store has no reset; only entries written in the current event are read.
`timescale 1ns / 1ps
module strip_cluster_coincidence_hits #(
	parameter int HODO_PER_LAYER = scch_pkg::HODO_PER_LAYER_DEF,
	parameter int STRIP_PER_SIDE = scch_pkg::STRIP_PER_SIDE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        is_strip,
	input  logic [4:0]  layer_code,
	input  logic [9:0]  cluster_id,
	input  logic [31:0] cluster_address,
	input  logic [17:0] mean_channel,
	input  logic [15:0] mean_error,
	input  logic [35:0] cluster_time,
	input  logic        last_cluster,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  station_code,
	output logic [9:0]  front_id,
	output logic [9:0]  back_id,
	output logic [31:0] hit_address,
	output logic [20:0] pos_x,
	output logic [20:0] pos_y,
	output logic [21:0] pos_z,
	output logic [17:0] err_x,
	output logic [17:0] err_y,
	output logic [35:0] hit_time,
	output logic        last_hit
);
	scch_pkg::cmd_t cmd;
	scch_pkg::sts_t sts;
	scch_pkg::hit_t hit;
	logic           hit_last;

	// sequencing: load, close, walk station kinds and pairs, flush
	scch_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .last_cluster(last_cluster),
		.sts(sts), .cmd(cmd), .in_stall(in_stall)
	);

	// store, window check, position/error arithmetic, hit registers
	scch_dp #(.HODO_PER_LAYER(HODO_PER_LAYER), .STRIP_PER_SIDE(STRIP_PER_SIDE)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.is_strip(is_strip), .layer_code(layer_code), .cluster_id(cluster_id),
		.cluster_address(cluster_address), .mean_channel(mean_channel),
		.mean_error(mean_error), .cluster_time(cluster_time),
		.out_stall(out_stall), .out_valid(out_valid), .out_hit(hit), .out_last(hit_last)
	);

	assign station_code = hit.station;
	assign front_id     = hit.front_id;
	assign back_id      = hit.back_id;
	assign hit_address  = hit.addr;
	assign pos_x        = hit.pos_x;
	assign pos_y        = hit.pos_y;
	assign pos_z        = hit.pos_z;
	assign err_x        = hit.err_x;
	assign err_y        = hit.err_y;
	assign hit_time     = hit.tm;
	assign last_hit     = hit_last;

	// no hit may linger in the pending slot once new requests are taken
	assert property (@(posedge clk) disable iff (!arst_n) !in_stall |-> !sts.pend_valid)
		else $error("pending hit left while accepting requests");

	// commit and flush only move data when the output register can take it
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit || cmd.flush) |-> sts.out_free)
		else $error("hit pushed into a full output register");

	// the last hit of an event is followed by reopening the input
	assert property (@(posedge clk) disable iff (!arst_n) cmd.flush |=> !in_stall)
		else $error("input still stalled after final hit");
endmodule
